// ===== hw/rtl/tpag_pkg.sv =====
// Package for the tensor permute address generator.
// Holds the field widths, register reset values, register indices and state codes.
// It depends on nothing else.
`default_nettype none

package tpag_pkg;

    localparam int MAX_AXES_DEF  = 8;
    localparam int DIM_BITS_DEF  = 16;
    localparam int ADDR_BITS_DEF = 32;
    localparam int ELEM_BITS_DEF = 64;

    localparam int AXIS_W      = 3;
    localparam int NUM_SLOTS   = 8;
    localparam int SLOT_W      = 16;
    localparam int RANK_W      = 4;
    localparam int DIMS_W      = 64;
    localparam int ORDER_W     = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int INDEX_W     = 32;

    localparam logic [RANK_W-1:0]  RANK_RST  = 4'd1;
    localparam logic [DIMS_W-1:0]  DIMS_RST  = 64'h0001_0001_0001_0001;
    localparam logic [ORDER_W-1:0] ORDER_RST = 24'hFAC688;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RANK       = 3'd0,
        REG_DIMS_LOW   = 3'd1,
        REG_DIMS_HIGH  = 3'd2,
        REG_AXIS_ORDER = 3'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_STRIDE = 2'd0,
        ST_WRAP   = 2'd1,
        ST_RUN    = 2'd2
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tensor_permute_address_gen_top.sv =====
// Top level of the tensor permute address generator.
// Takes its constants and types from tpag_pkg.
// Usage:
//   Elements arrive in source row-major order on the input channel (in_valid, in_stall,
//   element). Each beat leaves on the output channel (out_valid, out_stall) with its
//   destination index in the permuted tensor and a flag on the final element.
//   Registers are written on the configuration channel (cfg_valid, cfg_ready, cfg_index,
//   cfg_data); cfg_ready is always high. Indices 0 to 3 select rank, dims_low, dims_high
//   and axis_order; other indices are ignored.
//   Each write to indices 0 to 3, and reset, restarts the odometer and starts a
//   coefficient pass (a stride pass, then a wrap pass, over the axes), during which
//   in_stall is high. The address update is one add of a precomputed increment.
//   After that one element is accepted every cycle while the skid register is empty.
//   Each result is registered when its element is accepted.
//   When the receiver stalls, a skid register holds one more result; in_stall rises only
//   once that register is full, so no result is lost.
`default_nettype none

module tensor_permute_address_gen_top
    import tpag_pkg::*;
#(
    parameter int MAX_AXES  = MAX_AXES_DEF,
    parameter int DIM_BITS  = DIM_BITS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int ELEM_BITS = ELEM_BITS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [ELEM_BITS-1:0]   element,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [INDEX_W-1:0]     dest_index,
    output logic [ELEM_BITS-1:0]   element_out,
    output logic                   is_last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PROD_W = ADDR_BITS + DIM_BITS;
    localparam logic [AXIS_W-1:0] STEP_TOP = AXIS_W'(MAX_AXES - 1);

    logic [RANK_W-1:0]    rank_reg;
    logic [DIMS_W-1:0]    dims_low_reg;
    logic [DIMS_W-1:0]    dims_high_reg;
    logic [ORDER_W-1:0]   axis_order_reg;

    state_t               state_reg, state_next;
    logic [AXIS_W-1:0]    step_reg, step_next;
    logic [ADDR_BITS-1:0] acc_reg, acc_next;
    logic [ADDR_BITS-1:0] wacc_reg, wacc_next;
    logic [ADDR_BITS-1:0] coef_reg [MAX_AXES];
    logic [ADDR_BITS-1:0] coef_next [MAX_AXES];
    logic [ADDR_BITS-1:0] inc_reg [MAX_AXES];
    logic [ADDR_BITS-1:0] inc_next [MAX_AXES];

    logic [DIM_BITS-1:0]  cnt_reg [MAX_AXES];
    logic [DIM_BITS-1:0]  cnt_next [MAX_AXES];
    logic [DIM_BITS:0]    cnt_plus [MAX_AXES];
    logic [ADDR_BITS-1:0] dest_address_reg, dest_address_next;

    logic                 out_valid_reg, skid_valid_reg;
    logic [ADDR_BITS-1:0] out_addr_reg, skid_addr_reg;
    logic [ELEM_BITS-1:0] out_elem_reg, skid_elem_reg;
    logic                 out_last_reg, skid_last_reg;

    logic [DIM_BITS-1:0]  sizes [NUM_SLOTS];
    logic [RANK_W-1:0]    r_eff;
    logic                 cfg_fire, cfg_hit, accept, out_free;
    logic [AXIS_W-1:0]    ord;
    logic                 step_active, src_active;
    logic [PROD_W-1:0]    mul_stride, mul_wrap;
    logic [ADDR_BITS-1:0] coef_sel;
    logic [DIM_BITS-1:0]  size_step;
    logic [ADDR_BITS-1:0] delta;
    logic                 item_last;
    logic                 cnt_in_range;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign in_stall  = (state_reg != ST_RUN) | skid_valid_reg;
    assign accept    = in_valid & ~in_stall;
    assign out_free  = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        cfg_hit = 1'b0;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_RANK, REG_DIMS_LOW, REG_DIMS_HIGH, REG_AXIS_ORDER: cfg_hit = 1'b1;
                default: cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg       <= RANK_RST;
            dims_low_reg   <= DIMS_RST;
            dims_high_reg  <= DIMS_RST;
            axis_order_reg <= ORDER_RST;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_RANK:       rank_reg       <= cfg_data[RANK_W-1:0];
                REG_DIMS_LOW:   dims_low_reg   <= cfg_data[DIMS_W-1:0];
                REG_DIMS_HIGH:  dims_high_reg  <= cfg_data[DIMS_W-1:0];
                REG_AXIS_ORDER: axis_order_reg <= cfg_data[ORDER_W-1:0];
                default: ;
            endcase
        end
    end

    // A size of zero counts as one; rank is clamped to the range 1 to MAX_AXES.
    always_comb
    begin
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (s < NUM_SLOTS / 2)
                sizes[s] = dims_low_reg[SLOT_W * s +: DIM_BITS];
            else
                sizes[s] = dims_high_reg[SLOT_W * (s - NUM_SLOTS / 2) +: DIM_BITS];
            if (sizes[s] == '0)
                sizes[s] = DIM_BITS'(1);
        end
        if (rank_reg == '0)
            r_eff = RANK_W'(1);
        else if (rank_reg > RANK_W'(MAX_AXES))
            r_eff = RANK_W'(MAX_AXES);
        else
            r_eff = rank_reg;
    end

    // The first pass gathers each source axis's address coefficient; the second turns them
    // into the address increment for a carry that stops at that axis.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        wacc_next  = wacc_reg;
        coef_next  = coef_reg;
        inc_next   = inc_reg;

        ord         = axis_order_reg[AXIS_W * step_reg +: AXIS_W];
        step_active = ({1'b0, step_reg} < r_eff);
        src_active  = ({1'b0, ord} < r_eff);
        size_step   = sizes[step_reg];
        coef_sel    = '0;
        for (int j = 0; j < MAX_AXES; j++)
        begin
            if (AXIS_W'(j) == step_reg)
                coef_sel = coef_reg[j];
        end
        mul_stride = {{DIM_BITS{1'b0}}, acc_reg} * {{ADDR_BITS{1'b0}}, sizes[ord]};
        mul_wrap   = {{DIM_BITS{1'b0}}, coef_sel}
                   * {{ADDR_BITS{1'b0}}, size_step - DIM_BITS'(1)};

        unique case (state_reg)
            ST_STRIDE:
            begin
                if (step_active && src_active)
                begin
                    for (int j = 0; j < MAX_AXES; j++)
                    begin
                        if (AXIS_W'(j) == ord)
                            coef_next[j] = coef_reg[j] + acc_reg;
                    end
                    acc_next = mul_stride[ADDR_BITS-1:0];
                end
                if (step_reg == '0)
                begin
                    state_next = ST_WRAP;
                    step_next  = STEP_TOP;
                    wacc_next  = '0;
                end
                else
                    step_next = step_reg - AXIS_W'(1);
            end
            ST_WRAP:
            begin
                if (step_active)
                begin
                    for (int j = 0; j < MAX_AXES; j++)
                    begin
                        if (AXIS_W'(j) == step_reg)
                            inc_next[j] = coef_sel - wacc_reg;
                    end
                    wacc_next = wacc_reg + mul_wrap[ADDR_BITS-1:0];
                end
                if (step_reg == '0)
                    state_next = ST_RUN;
                else
                    step_next = step_reg - AXIS_W'(1);
            end
            ST_RUN: ;
            default: state_next = ST_STRIDE;
        endcase

        if (cfg_hit)
        begin
            state_next = ST_STRIDE;
            step_next  = STEP_TOP;
            acc_next   = ADDR_BITS'(1);
            for (int j = 0; j < MAX_AXES; j++)
                coef_next[j] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_STRIDE;
            step_reg  <= STEP_TOP;
            acc_reg   <= ADDR_BITS'(1);
            wacc_reg  <= '0;
            for (int j = 0; j < MAX_AXES; j++)
                coef_reg[j] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            acc_reg   <= acc_next;
            wacc_reg  <= wacc_next;
            coef_reg  <= coef_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inc_reg <= inc_next;
    end

    // The carry runs from the last axis towards axis 0.
    always_comb
    begin
        cnt_next  = cnt_reg;
        delta     = '0;
        item_last = 1'b1;
        for (int j = 0; j < MAX_AXES; j++)
            cnt_plus[j] = {1'b0, cnt_reg[j]} + (DIM_BITS + 1)'(1);
        for (int j = MAX_AXES - 1; j >= 0; j--)
        begin
            if ((j < int'(r_eff)) && item_last)
            begin
                if (cnt_plus[j] >= {1'b0, sizes[j]})
                    cnt_next[j] = '0;
                else
                begin
                    cnt_next[j] = cnt_plus[j][DIM_BITS-1:0];
                    delta       = inc_reg[j];
                    item_last   = 1'b0;
                end
            end
        end
        dest_address_next = item_last ? '0 : dest_address_reg + delta;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_address_reg <= '0;
            for (int j = 0; j < MAX_AXES; j++)
                cnt_reg[j] <= '0;
        end
        else if (cfg_hit)
        begin
            dest_address_reg <= '0;
            for (int j = 0; j < MAX_AXES; j++)
                cnt_reg[j] <= '0;
        end
        else if (accept)
        begin
            dest_address_reg <= dest_address_next;
            cnt_reg          <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (out_free)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && out_free)
        begin
            out_addr_reg <= dest_address_reg;
            out_elem_reg <= element;
            out_last_reg <= item_last;
        end
        else if (!accept && out_free && skid_valid_reg)
        begin
            out_addr_reg <= skid_addr_reg;
            out_elem_reg <= skid_elem_reg;
            out_last_reg <= skid_last_reg;
        end
        if (accept && !out_free)
        begin
            skid_addr_reg <= dest_address_reg;
            skid_elem_reg <= element;
            skid_last_reg <= item_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign dest_index  = INDEX_W'(out_addr_reg);
    assign element_out = out_elem_reg;
    assign is_last     = out_last_reg;

    always_comb
    begin
        cnt_in_range = 1'b1;
        for (int j = 0; j < MAX_AXES; j++)
        begin
            if ((j < int'(r_eff)) && (cnt_reg[j] >= sizes[j]))
                cnt_in_range = 1'b0;
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds a beat while the output register is empty.");

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> in_stall)
        else $error("Input accepted straight after a register write.");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item_last && !cfg_hit) |=> (dest_address_reg == '0))
        else $error("Address did not return to zero after the final element.");

    a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> cnt_in_range)
        else $error("An axis counter has reached its axis size.");

endmodule

`default_nettype wire
